// ===== rtl/srrw_pkg.sv =====
package srrw_pkg;

    // Field widths of one input word and one result word.
    localparam int PTYPE_W      = 8;
    localparam int SEQ_W        = 32;
    localparam int LEN_W        = 11;
    localparam int SLOT_INDEX_W = 3;

    // Bytes of packet header in front of the payload.
    localparam int HEADER_BYTES = 16;

    // Packet type codes. Any code other than these two marks an end packet.
    localparam logic [PTYPE_W-1:0] PKT_DATA  = 8'd0;
    localparam logic [PTYPE_W-1:0] PKT_BEGIN = 8'd1;

    // Result kinds.
    typedef enum logic
    {
        KIND_RELEASE = 1'b0,
        KIND_ACK     = 1'b1
    } result_kind_t;

endpackage

// ===== rtl/srrw_ram.sv =====
module srrw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/selective_repeat_receiver_window.sv =====
// Receiver side of a selective-repeat window.
//
// A header word (packet_type, seq_number, received_length) is taken at a
// rising edge with start high and busy low; busy then stays high until the
// word has been handled. Every word gives zero or more releases (result_kind
// 0: slot_index and content_length of a slot to write out, in order) and then
// one acknowledgement (result_kind 1: ack_number, done_flag, last high). Each
// result shows for one cycle with result_valid high; the receiver cannot stall.
//
// One shared compare unit walks the slots from the oldest, reading a slot's
// sequence in ST_SRCH_RD and comparing it in ST_SRCH_CMP, since slot sequences
// live in a memory with registered read. A word that matches no slot is
// compared against every slot before its acknowledgement; a repeated begin
// goes straight to the acknowledgement. The next word can be taken while
// the acknowledgement of the last one shows.
//
// Reset empties all slots, gives each slot its own index as sequence (through
// per-slot written bits, no clearing pass) and clears the finished flag.
module selective_repeat_receiver_window
    import srrw_pkg::*;
#(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [PTYPE_W-1:0]      packet_type,
    input  logic [SEQ_W-1:0]        seq_number,
    input  logic [LEN_W-1:0]        received_length,
    output logic                    result_valid,
    output logic                    result_kind,
    output logic [SLOT_INDEX_W-1:0] slot_index,
    output logic [LEN_W-1:0]        content_length,
    output logic [SEQ_W-1:0]        ack_number,
    output logic                    done_flag,
    output logic                    last
);

    localparam int IDX_W = $clog2(WINDOW_SLOTS);
    localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_BEG_RD,
        ST_BEG_WR,
        ST_REL_RD,
        ST_REL_WR,
        ST_ACK_RD,
        ST_ACK_OUT
    } state_t;

    state_t                   state_reg, state_next;
    logic [PTYPE_W-1:0]       ptype_reg, ptype_next;
    logic [SEQ_W-1:0]         seq_reg, seq_next;
    logic [LEN_W-1:0]         rlen_reg, rlen_next;
    logic [IDX_W-1:0]         cur_reg, cur_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         oldest_reg, oldest_next;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic                     finished_reg, finished_next;
    logic                     begun_reg, begun_next;
    logic [WINDOW_SLOTS-1:0]  loaded_reg, loaded_next;
    logic [WINDOW_SLOTS-1:0]  is_end_reg, is_end_next;
    logic [WINDOW_SLOTS-1:0]  written_reg, written_next;

    logic                     valid_reg, valid_next;
    logic                     kind_reg, kind_next;
    logic [SLOT_INDEX_W-1:0]  index_reg, index_next;
    logic [LEN_W-1:0]         clen_reg, clen_next;
    logic [SEQ_W-1:0]         ackn_reg, ackn_next;
    logic                     done_reg, done_next;
    logic                     last_reg, last_next;

    logic [IDX_W-1:0]         rd_addr;
    logic [SEQ_W-1:0]         seq_rdata;
    logic [SEQ_W-1:0]         seq_val;
    logic                     seq_we;
    logic [IDX_W-1:0]         seq_waddr;
    logic [SEQ_W-1:0]         seq_wdata;
    logic                     len_we;
    logic [LEN_W-1:0]         len_wdata;
    logic [LEN_W-1:0]         len_rdata;
    logic [LEN_W-1:0]         payload_len;
    logic [IDX_W-1:0]         cur_succ;

    function automatic logic [IDX_W-1:0] succ_idx(input logic [IDX_W-1:0] x);
        logic [IDX_W-1:0] r;
        if (x == IDX_W'(WINDOW_SLOTS - 1))
        begin
            r = '0;
        end
        else
        begin
            r = x + IDX_W'(1);
        end
        return r;
    endfunction

    // Slot sequence numbers and slot payload lengths.
    srrw_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (WINDOW_SLOTS)
    ) u_seq_ram (
        .clk   (clk),
        .we    (seq_we),
        .waddr (seq_waddr),
        .wdata (seq_wdata),
        .raddr (rd_addr),
        .rdata (seq_rdata)
    );

    srrw_ram #(
        .WIDTH (LEN_W),
        .DEPTH (WINDOW_SLOTS)
    ) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (cur_reg),
        .wdata (len_wdata),
        .raddr (rd_addr),
        .rdata (len_rdata)
    );

    // A slot never written still holds its reset sequence, its own index.
    assign seq_val = written_reg[rd_idx_reg] ? seq_rdata : SEQ_W'(rd_idx_reg);

    // Payload length with the header removed, floored at zero.
    assign payload_len = (rlen_reg > LEN_W'(HEADER_BYTES))
                         ? (rlen_reg - LEN_W'(HEADER_BYTES)) : '0;

    assign cur_succ = succ_idx(cur_reg);

    // Read address of both memories in each state.
    always_comb
    begin
        case (state_reg)
            ST_BEG_RD: rd_addr = '0;
            ST_ACK_RD: rd_addr = oldest_reg;
            default:   rd_addr = cur_reg;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        ptype_next    = ptype_reg;
        seq_next      = seq_reg;
        rlen_next     = rlen_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        oldest_next   = oldest_reg;
        finished_next = finished_reg;
        begun_next    = begun_reg;
        loaded_next   = loaded_reg;
        is_end_next   = is_end_reg;
        written_next  = written_reg;
        valid_next    = 1'b0;
        kind_next     = kind_reg;
        index_next    = index_reg;
        clen_next     = clen_reg;
        ackn_next     = ackn_reg;
        done_next     = done_reg;
        last_next     = last_reg;
        seq_we        = 1'b0;
        seq_waddr     = cur_reg;
        seq_wdata     = seq_val + SEQ_W'(WINDOW_SLOTS);
        len_we        = 1'b0;
        len_wdata     = payload_len;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ptype_next = packet_type;
                    seq_next   = seq_number;
                    rlen_next  = received_length;
                    cur_next   = oldest_reg;
                    cnt_next   = '0;
                    if (packet_type == PKT_BEGIN)
                    begin
                        state_next = begun_reg ? ST_ACK_RD : ST_BEG_RD;
                    end
                    else
                    begin
                        state_next = ST_SRCH_RD;
                    end
                end
            end

            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end

            // Compare one slot's sequence with the packet's sequence.
            ST_SRCH_CMP:
            begin
                if (seq_val == seq_reg)
                begin
                    if (!loaded_reg[cur_reg])
                    begin
                        loaded_next[cur_reg] = 1'b1;
                        is_end_next[cur_reg] = (ptype_reg != PKT_DATA);
                        len_we               = 1'b1;
                        cur_next             = oldest_reg;
                        cnt_next             = '0;
                        state_next           = ST_REL_RD;
                    end
                    else
                    begin
                        state_next = ST_ACK_RD;
                    end
                end
                else if (cnt_reg == CNT_W'(WINDOW_SLOTS - 1))
                begin
                    state_next = ST_ACK_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    cur_next   = cur_succ;
                    state_next = ST_SRCH_RD;
                end
            end

            ST_BEG_RD:
            begin
                state_next = ST_BEG_WR;
            end

            // First begin packet: slot 0 moves on, slot 1 becomes the oldest.
            ST_BEG_WR:
            begin
                seq_we          = 1'b1;
                seq_waddr       = '0;
                written_next[0] = 1'b1;
                is_end_next[0]  = 1'b0;
                begun_next      = 1'b1;
                oldest_next     = IDX_W'(1);
                cur_next        = IDX_W'(1);
                cnt_next        = '0;
                state_next      = ST_REL_RD;
            end

            // Stop releasing at the first empty slot or after a full lap.
            ST_REL_RD:
            begin
                if ((cnt_reg == CNT_W'(WINDOW_SLOTS)) || !loaded_reg[cur_reg])
                begin
                    oldest_next = cur_reg;
                    state_next  = ST_ACK_RD;
                end
                else
                begin
                    state_next = ST_REL_WR;
                end
            end

            // Release one slot and advance its sequence by the window size.
            ST_REL_WR:
            begin
                valid_next   = 1'b1;
                kind_next    = KIND_RELEASE;
                index_next   = SLOT_INDEX_W'(cur_reg);
                clen_next    = len_rdata;
                ackn_next    = '0;
                done_next    = 1'b0;
                last_next    = 1'b0;
                seq_we       = 1'b1;
                written_next[cur_reg] = 1'b1;
                loaded_next[cur_reg]  = 1'b0;
                if (is_end_reg[cur_reg])
                begin
                    finished_next = 1'b1;
                end
                cur_next   = cur_succ;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = ST_REL_RD;
            end

            ST_ACK_RD:
            begin
                state_next = ST_ACK_OUT;
            end

            // Acknowledge with the sequence of the oldest slot.
            ST_ACK_OUT:
            begin
                valid_next = 1'b1;
                kind_next  = KIND_ACK;
                index_next = '0;
                clen_next  = '0;
                ackn_next  = seq_val;
                done_next  = finished_reg;
                last_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ptype_reg    <= '0;
            seq_reg      <= '0;
            rlen_reg     <= '0;
            cur_reg      <= '0;
            cnt_reg      <= '0;
            oldest_reg   <= '0;
            rd_idx_reg   <= '0;
            finished_reg <= 1'b0;
            begun_reg    <= 1'b0;
            loaded_reg   <= '0;
            is_end_reg   <= '0;
            written_reg  <= '0;
            valid_reg    <= 1'b0;
            kind_reg     <= KIND_RELEASE;
            index_reg    <= '0;
            clen_reg     <= '0;
            ackn_reg     <= '0;
            done_reg     <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptype_reg    <= ptype_next;
            seq_reg      <= seq_next;
            rlen_reg     <= rlen_next;
            cur_reg      <= cur_next;
            cnt_reg      <= cnt_next;
            oldest_reg   <= oldest_next;
            rd_idx_reg   <= rd_addr;
            finished_reg <= finished_next;
            begun_reg    <= begun_next;
            loaded_reg   <= loaded_next;
            is_end_reg   <= is_end_next;
            written_reg  <= written_next;
            valid_reg    <= valid_next;
            kind_reg     <= kind_next;
            index_reg    <= index_next;
            clen_reg     <= clen_next;
            ackn_reg     <= ackn_next;
            done_reg     <= done_next;
            last_reg     <= last_next;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result_valid   = valid_reg;
    assign result_kind    = kind_reg;
    assign slot_index     = index_reg;
    assign content_length = clen_reg;
    assign ack_number     = ackn_reg;
    assign done_flag      = done_reg;
    assign last           = last_reg;

    // The acknowledgement closes a word, so the block is free while it shows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg == KIND_ACK)) |-> !busy)
        else $error("acknowledgement shown while still busy");

    // A release is shown while the word is still being handled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (kind_reg == KIND_RELEASE)) |-> busy)
        else $error("release shown after the word was closed");

    // Only the acknowledgement carries the last mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (last_reg == (kind_reg == KIND_ACK)))
        else $error("last mark does not match result kind");

    // An accepted word always occupies the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not start the sequencer");

    // The transfer never becomes unfinished again.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(finished_reg) |-> finished_reg)
        else $error("finished flag cleared");

endmodule
